// File: src/avdc_pkg.sv
// ----------------------------------------------------------------------------
// avdc_pkg
// Shared types, register codes and constants of the valve duty controller.
// ----------------------------------------------------------------------------
package avdc_pkg;

    // zone storage
    localparam int ZONES   = 8;
    localparam int ZONE_AW = (ZONES > 1) ? $clog2(ZONES) : 1;
    localparam logic [4:0] ZONE_LIMIT = 5'(ZONES);

    typedef logic [ZONE_AW-1:0] zaddr_t;

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = FIFO_AW + 1;

    typedef logic [FIFO_AW-1:0] fptr_t;
    typedef logic [CNT_W-1:0]   fcnt_t;

    // register indexes
    localparam logic [2:0] REG_SAMPLE_INTERVAL = 3'd0;
    localparam logic [2:0] REG_HYSTERESIS      = 3'd1;
    localparam logic [2:0] REG_DUTY_STEP       = 3'd2;
    localparam logic [2:0] REG_OVERHEAT_LIMIT  = 3'd3;
    localparam logic [2:0] REG_DEFAULT_DUTY    = 3'd4;
    localparam logic [2:0] REG_MAX_DUTY        = 3'd5;
    localparam logic [2:0] REG_PWM_PERIOD      = 3'd6;
    localparam logic [2:0] REG_ZONE_ENABLE     = 3'd7;

    // register reset values
    localparam logic [15:0] RST_SAMPLE_INTERVAL = 16'd1200;
    localparam logic [8:0]  RST_HYSTERESIS      = 9'd5;
    localparam logic [15:0] RST_DUTY_STEP       = 16'd60;
    localparam logic [11:0] RST_OVERHEAT_LIMIT  = 12'd900;
    localparam logic [15:0] RST_DEFAULT_DUTY    = 16'd600;
    localparam logic [15:0] RST_MAX_DUTY        = 16'd1200;
    localparam logic [15:0] RST_PWM_PERIOD      = 16'd1200;
    localparam logic [7:0]  RST_ZONE_ENABLE     = 8'd0;

    // derived values at reset
    localparam logic [9:0]  RST_PERIOD_DIV    = 10'(RST_PWM_PERIOD / 100);
    localparam logic [16:0] RST_STEP_X2       = 17'(RST_DUTY_STEP) * 17'd2;
    localparam logic [17:0] RST_STEP_X3       = 18'(RST_DUTY_STEP) * 18'd3;
    localparam logic [16:0] RST_MAX_LESS_STEP = 17'(RST_MAX_DUTY) - 17'(RST_DUTY_STEP);

    // period / 100 as multiply by reciprocal, exact for 16-bit periods
    localparam logic [17:0] DIV100_RECIP = 18'd167773;
    localparam int          DIV100_SHIFT = 24;

    // temperature thresholds, tenths of a degree
    localparam logic signed [14:0] TREND_DROP = 15'sd15;
    localparam logic signed [14:0] SLOW_RISE  = 15'sd15;
    localparam logic signed [14:0] FAR_BELOW  = 15'sd30;
    localparam logic signed [14:0] FAR_ABOVE  = 15'sd100;
    localparam logic [2:0]         RISE_LIMIT = 3'd4;

    typedef struct packed {
        logic [15:0] sample_interval;
        logic [8:0]  hysteresis;
        logic [15:0] duty_step;
        logic [11:0] overheat_limit;
        logic [15:0] default_duty;
        logic [15:0] max_duty;
        logic [15:0] pwm_period;
        logic [7:0]  zone_enable;
        logic [9:0]  period_div;
        logic [16:0] step_x2;
        logic [17:0] step_x3;
        logic [16:0] max_less_step;
    } cfg_t;

    typedef struct packed {
        logic [11:0] hist0;
        logic [11:0] hist1;
        logic [11:0] hist2;
        logic [16:0] holdoff;
        logic [15:0] below;
        logic [2:0]  rise;
        logic        hot;
        logic        cold;
        logic        heat;
        logic [15:0] width;
    } zone_rec_t;

    typedef struct packed {
        logic [2:0]  zone;
        logic        valve_open;
        logic        duty_active;
        logic [15:0] pulse_width;
        logic        heat_request;
    } result_t;

    typedef struct packed {
        logic       s1_valid;
        logic [2:0] s1_zone;
        logic       s2_valid;
        logic [2:0] s2_zone;
        logic [1:0] in_flight;
    } pipe_status_t;

endpackage

// File: src/avdc_ram.sv
// ----------------------------------------------------------------------------
// avdc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module avdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/avdc_cfg_regs.sv
// ----------------------------------------------------------------------------
// avdc_cfg_regs
// Configuration registers and the values derived from them.
// ----------------------------------------------------------------------------
module avdc_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  logic [2:0]    wr_index,
    input  logic [15:0]   wr_data,
    output avdc_pkg::cfg_t cfg
);

    logic [15:0] sample_interval_reg, sample_interval_next;
    logic [8:0]  hysteresis_reg, hysteresis_next;
    logic [15:0] duty_step_reg, duty_step_next;
    logic [11:0] overheat_limit_reg, overheat_limit_next;
    logic [15:0] default_duty_reg, default_duty_next;
    logic [15:0] max_duty_reg, max_duty_next;
    logic [15:0] pwm_period_reg, pwm_period_next;
    logic [7:0]  zone_enable_reg, zone_enable_next;
    logic [9:0]  period_div_reg, period_div_next;
    logic [16:0] step_x2_reg, step_x2_next;
    logic [17:0] step_x3_reg, step_x3_next;
    logic [16:0] max_less_step_reg, max_less_step_next;
    logic [33:0] period_prod;

    // register writes
    always_comb
    begin
        sample_interval_next = sample_interval_reg;
        hysteresis_next      = hysteresis_reg;
        duty_step_next       = duty_step_reg;
        overheat_limit_next  = overheat_limit_reg;
        default_duty_next    = default_duty_reg;
        max_duty_next        = max_duty_reg;
        pwm_period_next      = pwm_period_reg;
        zone_enable_next     = zone_enable_reg;
        if (wr_en)
        begin
            case (wr_index)
                avdc_pkg::REG_SAMPLE_INTERVAL: sample_interval_next = wr_data;
                avdc_pkg::REG_HYSTERESIS:      hysteresis_next      = wr_data[8:0];
                avdc_pkg::REG_DUTY_STEP:       duty_step_next       = wr_data;
                avdc_pkg::REG_OVERHEAT_LIMIT:  overheat_limit_next  = wr_data[11:0];
                avdc_pkg::REG_DEFAULT_DUTY:    default_duty_next    = wr_data;
                avdc_pkg::REG_MAX_DUTY:        max_duty_next        = wr_data;
                avdc_pkg::REG_PWM_PERIOD:      pwm_period_next      = wr_data;
                avdc_pkg::REG_ZONE_ENABLE:     zone_enable_next     = wr_data[7:0];
                default:                       sample_interval_next = sample_interval_reg;
            endcase
        end
    end

    // derived values, following the registers in the next cycle
    always_comb
    begin
        period_prod        = {18'd0, pwm_period_reg} * {16'd0, avdc_pkg::DIV100_RECIP};
        period_div_next    = period_prod[avdc_pkg::DIV100_SHIFT +: 10];
        step_x2_next       = {duty_step_reg, 1'b0};
        step_x3_next       = {2'b00, duty_step_reg} + {1'b0, duty_step_reg, 1'b0};
        max_less_step_next = {1'b0, max_duty_reg} - {1'b0, duty_step_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_interval_reg <= avdc_pkg::RST_SAMPLE_INTERVAL;
            hysteresis_reg      <= avdc_pkg::RST_HYSTERESIS;
            duty_step_reg       <= avdc_pkg::RST_DUTY_STEP;
            overheat_limit_reg  <= avdc_pkg::RST_OVERHEAT_LIMIT;
            default_duty_reg    <= avdc_pkg::RST_DEFAULT_DUTY;
            max_duty_reg        <= avdc_pkg::RST_MAX_DUTY;
            pwm_period_reg      <= avdc_pkg::RST_PWM_PERIOD;
            zone_enable_reg     <= avdc_pkg::RST_ZONE_ENABLE;
            period_div_reg      <= avdc_pkg::RST_PERIOD_DIV;
            step_x2_reg         <= avdc_pkg::RST_STEP_X2;
            step_x3_reg         <= avdc_pkg::RST_STEP_X3;
            max_less_step_reg   <= avdc_pkg::RST_MAX_LESS_STEP;
        end
        else
        begin
            sample_interval_reg <= sample_interval_next;
            hysteresis_reg      <= hysteresis_next;
            duty_step_reg       <= duty_step_next;
            overheat_limit_reg  <= overheat_limit_next;
            default_duty_reg    <= default_duty_next;
            max_duty_reg        <= max_duty_next;
            pwm_period_reg      <= pwm_period_next;
            zone_enable_reg     <= zone_enable_next;
            period_div_reg      <= period_div_next;
            step_x2_reg         <= step_x2_next;
            step_x3_reg         <= step_x3_next;
            max_less_step_reg   <= max_less_step_next;
        end
    end

    // register bank out
    always_comb
    begin
        cfg.sample_interval = sample_interval_reg;
        cfg.hysteresis      = hysteresis_reg;
        cfg.duty_step       = duty_step_reg;
        cfg.overheat_limit  = overheat_limit_reg;
        cfg.default_duty    = default_duty_reg;
        cfg.max_duty        = max_duty_reg;
        cfg.pwm_period      = pwm_period_reg;
        cfg.zone_enable     = zone_enable_reg;
        cfg.period_div      = period_div_reg;
        cfg.step_x2         = step_x2_reg;
        cfg.step_x3         = step_x3_reg;
        cfg.max_less_step   = max_less_step_reg;
    end

endmodule

// File: src/avdc_zone_engine.sv
// ----------------------------------------------------------------------------
// avdc_zone_engine
// Per-zone read-modify-write pipeline over the zone state memory.
// ----------------------------------------------------------------------------
module avdc_zone_engine (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic [2:0]             zone,
    input  logic [11:0]            measured_temp,
    input  logic [11:0]            target_temp,
    input  logic [15:0]            cycle_timer,
    input  logic                   sample_tick,
    input  avdc_pkg::cfg_t         cfg,
    output avdc_pkg::pipe_status_t status,
    output logic                   res_valid,
    output avdc_pkg::result_t      res
);

    // width update selections for the second stage
    localparam logic [2:0] WOP_KEEP = 3'd0;
    localparam logic [2:0] WOP_ADD  = 3'd1;
    localparam logic [2:0] WOP_HEAT = 3'd2;
    localparam logic [2:0] WOP_DEC1 = 3'd3;
    localparam logic [2:0] WOP_DEC2 = 3'd4;

    localparam int REC_W = $bits(avdc_pkg::zone_rec_t);

    function automatic logic signed [14:0] sx15(input logic [11:0] v);
        return $signed({{3{v[11]}}, v});
    endfunction

    // state memory and valid bits
    logic [REC_W-1:0]      rd_data;
    logic                  wr_en;
    avdc_pkg::zaddr_t      rd_addr;
    avdc_pkg::zone_rec_t   wr_rec;
    logic [avdc_pkg::ZONES-1:0] seen_reg, seen_next;
    logic                  in_range;

    // stage 1 registers
    logic        s1_valid_reg, s1_valid_next;
    logic [2:0]  s1_zone_reg;
    logic        s1_range_reg;
    logic        s1_seen_reg;
    logic [11:0] s1_meas_reg;
    logic [11:0] s1_targ_reg;
    logic [15:0] s1_ct_reg;
    logic        s1_tick_reg;

    // stage 1 logic
    avdc_pkg::zone_rec_t rec;
    avdc_pkg::zone_rec_t rec_next;
    logic [11:0]       hist1_new, hist2_new;
    logic signed [14:0] mx, ax, bx, tx, hyst_x, hi, lo, top_x;
    logic signed [14:0] d_am, d_ma, d_lom, d_ahi, d_bhi, d_mhi;
    logic              hold_busy, m_gt_hi, m_lt_lo, m_hot;
    logic              c1, c2, fall, rising, far_below, far_above, slow_rise;
    logic              ovh_all, ge_w, ge_d, ovh_cap;
    logic [15:0]       sub1;
    logic [15:0]       below_inc;
    logic              below_hit_next;
    logic [2:0]        op_next;
    logic [16:0]       add_next;

    // stage 2 registers
    logic                s2_valid_reg;
    logic [2:0]          s2_zone_reg;
    logic                s2_range_reg;
    avdc_pkg::zone_rec_t s2_rec_reg;
    logic [2:0]          s2_op_reg;
    logic [16:0]         s2_add_reg;
    logic                s2_below_hit_reg;
    logic [15:0]         s2_ct_reg;

    // stage 2 logic
    logic [15:0] wa, w3, heat_sat, heat_w, add_w, dec1_w, dec2_w, width_next;
    logic [17:0] heat_sum;
    logic [16:0] add_sum, dec2_diff;

    // stage 3 registers
    logic        s3_valid_reg;
    logic [2:0]  s3_zone_reg;
    logic        s3_range_reg;
    logic [15:0] s3_width_reg;
    logic        s3_heat_reg;
    logic [15:0] s3_ct_reg;

    // stage 3 logic
    logic signed [17:0] window_lo;
    logic               active;

    assign rd_addr  = avdc_pkg::zaddr_t'(zone);
    assign in_range = {2'b00, zone} < avdc_pkg::ZONE_LIMIT;

    avdc_ram #(
        .WIDTH (REC_W),
        .DEPTH (avdc_pkg::ZONES)
    ) u_state_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (avdc_pkg::zaddr_t'(s2_zone_reg)),
        .wr_data (wr_rec),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // stage 1: operands, trend and band decisions
    always_comb
    begin
        rec = s1_seen_reg ? avdc_pkg::zone_rec_t'(rd_data) : '0;

        hist1_new = s1_tick_reg ? rec.hist0 : rec.hist1;
        hist2_new = s1_tick_reg ? rec.hist1 : rec.hist2;

        mx     = sx15(s1_meas_reg);
        ax     = sx15(hist2_new);
        bx     = sx15(hist1_new);
        tx     = sx15(s1_targ_reg);
        hyst_x = $signed({6'b000000, cfg.hysteresis});
        hi     = tx + hyst_x;
        lo     = tx - hyst_x;
        top_x  = sx15(cfg.overheat_limit);

        d_am  = ax - mx;
        d_ma  = mx - ax;
        d_lom = lo - mx;
        d_ahi = ax - hi;
        d_bhi = bx - hi;
        d_mhi = mx - hi;

        hold_busy = rec.holdoff != 17'd0;
        m_gt_hi   = mx > hi;
        m_lt_lo   = mx < lo;
        m_hot     = mx > top_x;
        fall      = (ax > bx) && (bx > mx);
        rising    = (ax < bx) && (bx < mx);
        far_below = d_lom > avdc_pkg::FAR_BELOW;
        far_above = (d_ahi > avdc_pkg::FAR_ABOVE) && (d_bhi > avdc_pkg::FAR_ABOVE)
                    && (d_mhi > avdc_pkg::FAR_ABOVE);
        slow_rise = d_ma < avdc_pkg::SLOW_RISE;

        c1 = m_gt_hi && rec.heat && !rec.hot;
        c2 = !rec.cold && fall && (d_am > avdc_pkg::TREND_DROP);

        // overheat fallbacks to the default width
        ovh_all = m_hot && (bx > top_x) && (ax > top_x);
        ge_w    = $signed({1'b0, rec.width}) >= $signed(cfg.max_less_step);
        ge_d    = $signed({1'b0, cfg.default_duty}) >= $signed(cfg.max_less_step);
        ovh_cap = m_hot && (ovh_all ? ge_d : ge_w);

        sub1      = (rec.width > cfg.duty_step) ? (rec.width - cfg.duty_step) : 16'd0;
        below_inc = (rec.below != 16'hFFFF) ? (rec.below + 16'd1) : rec.below;
        below_hit_next = below_inc > {6'b000000, cfg.period_div};

        rec_next       = rec;
        rec_next.hist1 = hist1_new;
        rec_next.hist2 = hist2_new;
        rec_next.hist0 = s1_tick_reg ? s1_meas_reg : rec.hist0;
        op_next        = WOP_KEEP;
        add_next       = 17'd0;

        if (hold_busy)
        begin
            // hold-off running: overshoot and falling-trend reactions
            rec_next.holdoff = rec.holdoff - 17'd1;
            rec_next.width   = c1 ? sub1 : rec.width;
            if (c1)
            begin
                rec_next.heat = 1'b0;
                rec_next.rise = 3'd0;
                rec_next.hot  = 1'b1;
            end
            if (c2)
            begin
                rec_next.cold = 1'b1;
                op_next       = WOP_ADD;
            end
        end
        else
        begin
            rec_next.width = (ovh_all || ovh_cap) ? cfg.default_duty : rec.width;
            if (m_lt_lo)
            begin
                // below band: heat more
                rec_next.below   = below_inc;
                rec_next.cold    = 1'b0;
                rec_next.heat    = 1'b1;
                rec_next.holdoff = {cfg.pwm_period, 1'b0};
                op_next          = WOP_HEAT;
                if (rising)
                begin
                    if (rec.rise < avdc_pkg::RISE_LIMIT)
                    begin
                        rec_next.rise = rec.rise + 3'd1;
                    end
                    else if (slow_rise)
                    begin
                        add_next = {1'b0, cfg.duty_step};
                    end
                end
                else
                begin
                    add_next = far_below ? cfg.step_x2 : {1'b0, cfg.duty_step};
                end
            end
            else
            begin
                rec_next.heat  = 1'b0;
                rec_next.below = 16'd0;
                rec_next.hot   = 1'b0;
                rec_next.rise  = 3'd0;
                if (m_gt_hi)
                begin
                    // above band: back off
                    if (fall)
                    begin
                        op_next = far_above ? WOP_DEC2 : WOP_KEEP;
                    end
                    else
                    begin
                        op_next          = WOP_DEC1;
                        rec_next.holdoff = {1'b0, cfg.pwm_period};
                    end
                end
                else
                begin
                    rec_next.cold = 1'b0;
                end
            end
        end
    end

    // stage 2: final width and write back
    always_comb
    begin
        wa = s2_rec_reg.width;

        w3       = (s2_below_hit_reg && (wa < cfg.default_duty)) ? cfg.default_duty : wa;
        heat_sum = {2'b00, w3} + {1'b0, s2_add_reg};
        heat_sat = (heat_sum > 18'h0FFFF) ? 16'hFFFF : heat_sum[15:0];
        heat_w   = (heat_sat > cfg.max_duty) ? cfg.max_duty : heat_sat;

        add_sum = {1'b0, wa} + {1'b0, cfg.duty_step};
        add_w   = add_sum[16] ? 16'hFFFF : add_sum[15:0];

        dec1_w    = ({1'b0, wa} < cfg.step_x2) ? cfg.duty_step : (wa - cfg.duty_step);
        dec2_diff = {1'b0, wa} - cfg.step_x2;
        dec2_w    = ({2'b00, wa} < cfg.step_x3) ? cfg.duty_step : dec2_diff[15:0];

        case (s2_op_reg)
            WOP_KEEP: width_next = wa;
            WOP_ADD:  width_next = add_w;
            WOP_HEAT: width_next = heat_w;
            WOP_DEC1: width_next = dec1_w;
            WOP_DEC2: width_next = dec2_w;
            default:  width_next = wa;
        endcase

        wr_rec       = s2_rec_reg;
        wr_rec.width = width_next;
        wr_en        = s2_valid_reg && s2_range_reg;
    end

    // zones written at least once
    always_comb
    begin
        seen_next = seen_reg;
        if (wr_en)
        begin
            seen_next[avdc_pkg::zaddr_t'(s2_zone_reg)] = 1'b1;
        end
    end

    assign s1_valid_next = accept;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            seen_reg     <= seen_next;
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_zone_reg  <= zone;
            s1_range_reg <= in_range;
            s1_seen_reg  <= seen_reg[rd_addr];
            s1_meas_reg  <= measured_temp;
            s1_targ_reg  <= target_temp;
            s1_ct_reg    <= cycle_timer;
            s1_tick_reg  <= sample_tick;
        end
        s2_zone_reg      <= s1_zone_reg;
        s2_range_reg     <= s1_range_reg;
        s2_rec_reg       <= rec_next;
        s2_op_reg        <= op_next;
        s2_add_reg       <= add_next;
        s2_below_hit_reg <= below_hit_next;
        s2_ct_reg        <= s1_ct_reg;
        s3_zone_reg      <= s2_zone_reg;
        s3_range_reg     <= s2_range_reg;
        s3_width_reg     <= width_next;
        s3_heat_reg      <= s2_rec_reg.heat;
        s3_ct_reg        <= s2_ct_reg;
    end

    // stage 3: pulse window and valve drive
    always_comb
    begin
        window_lo = $signed({2'b00, cfg.pwm_period}) - $signed({2'b00, s3_width_reg});
        active    = $signed({2'b00, s3_ct_reg}) > window_lo;

        res.zone         = s3_zone_reg;
        res.duty_active  = s3_range_reg && active;
        res.valve_open   = s3_range_reg && active && cfg.zone_enable[s3_zone_reg];
        res.pulse_width  = s3_range_reg ? s3_width_reg : 16'd0;
        res.heat_request = s3_range_reg && s3_heat_reg;
        res_valid        = s3_valid_reg;
    end

    // occupancy and hazard info for the front end
    always_comb
    begin
        status.s1_valid  = s1_valid_reg;
        status.s1_zone   = s1_zone_reg;
        status.s2_valid  = s2_valid_reg;
        status.s2_zone   = s2_zone_reg;
        status.in_flight = {1'b0, s1_valid_reg} + {1'b0, s2_valid_reg}
                           + {1'b0, s3_valid_reg};
    end

endmodule

// File: src/avdc_result_fifo.sv
// ----------------------------------------------------------------------------
// avdc_result_fifo
// Result queue between the zone pipeline and the output channel.
// ----------------------------------------------------------------------------
module avdc_result_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  avdc_pkg::result_t push_data,
    input  logic              pop,
    output avdc_pkg::result_t head,
    output avdc_pkg::fcnt_t   count
);

    avdc_pkg::result_t mem_reg [avdc_pkg::FIFO_DEPTH];
    avdc_pkg::fptr_t   wr_ptr_reg, wr_ptr_next;
    avdc_pkg::fptr_t   rd_ptr_reg, rd_ptr_next;
    avdc_pkg::fcnt_t   count_reg, count_next;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = push ? (wr_ptr_reg + avdc_pkg::fptr_t'(1)) : wr_ptr_reg;
        rd_ptr_next = pop ? (rd_ptr_reg + avdc_pkg::fptr_t'(1)) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + avdc_pkg::fcnt_t'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - avdc_pkg::fcnt_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign count = count_reg;

endmodule

// File: src/adaptive_valve_duty_controller_unit.sv
// ----------------------------------------------------------------------------
// adaptive_valve_duty_controller_unit: multi-zone slow-PWM valve controller
// Result path: a taken zone transaction passes pipeline stages 1, 2 and 3, then the result queue.
// Throughput: one zone per cycle while the result queue has room; a repeat of a zone still in the state RMW waits.
// Reset (async rst_n) clears timers and queue, loads register reset values; zone state reads zero until first written.
// ----------------------------------------------------------------------------
module adaptive_valve_duty_controller_unit (
    input  logic               clk,
    input  logic               rst_n,
    // zone transactions
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [2:0]         zone,
    input  logic signed [11:0] measured_temp,
    input  logic signed [11:0] target_temp,
    input  logic               last_zone,
    // result transactions
    output logic               result_valid,
    input  logic               result_stall,
    output logic [2:0]         zone_out,
    output logic               valve_open,
    output logic               duty_active,
    output logic [15:0]        pulse_width,
    output logic               heat_request,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    avdc_pkg::cfg_t         cfg;
    avdc_pkg::pipe_status_t status;
    avdc_pkg::result_t      res;
    avdc_pkg::result_t      head;
    avdc_pkg::fcnt_t        fifo_count;
    avdc_pkg::fcnt_t        occupancy;
    logic                   res_valid;
    logic                   accept;
    logic                   queue_full;
    logic                   zone_hazard;
    logic                   pop;
    logic [15:0]            cycle_timer_reg, cycle_timer_next;
    logic [15:0]            sample_timer_reg, sample_timer_next;
    logic [15:0]            cycle_load, sample_load;

    assign cfg_ready = 1'b1;

    avdc_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // admission: room for every result in flight, no open RMW on the same zone
    always_comb
    begin
        occupancy   = avdc_pkg::fcnt_t'(status.in_flight) + fifo_count;
        queue_full  = occupancy >= avdc_pkg::fcnt_t'(avdc_pkg::FIFO_DEPTH);
        zone_hazard = (status.s1_valid && (status.s1_zone == zone))
                      || (status.s2_valid && (status.s2_zone == zone));
        item_stall  = queue_full || zone_hazard;
        accept      = item_valid && !item_stall;
    end

    // shared period and sample timers, advanced after the last zone of a tick
    always_comb
    begin
        cycle_load        = (cycle_timer_reg == 16'd0) ? cfg.pwm_period : cycle_timer_reg;
        sample_load       = (sample_timer_reg == 16'd0) ? cfg.sample_interval : sample_timer_reg;
        cycle_timer_next  = cycle_timer_reg;
        sample_timer_next = sample_timer_reg;
        if (accept && last_zone)
        begin
            cycle_timer_next  = cycle_load - 16'd1;
            sample_timer_next = sample_load - 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_timer_reg  <= 16'd0;
            sample_timer_reg <= 16'd0;
        end
        else
        begin
            cycle_timer_reg  <= cycle_timer_next;
            sample_timer_reg <= sample_timer_next;
        end
    end

    avdc_zone_engine u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .zone          (zone),
        .measured_temp (measured_temp),
        .target_temp   (target_temp),
        .cycle_timer   (cycle_timer_reg),
        .sample_tick   (sample_timer_reg == 16'd0),
        .cfg           (cfg),
        .status        (status),
        .res_valid     (res_valid),
        .res           (res)
    );

    avdc_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .pop       (pop),
        .head      (head),
        .count     (fifo_count)
    );

    // result channel
    always_comb
    begin
        result_valid = fifo_count != '0;
        pop          = result_valid && !result_stall;
        zone_out     = head.zone;
        valve_open   = head.valve_open;
        duty_active  = head.duty_active;
        pulse_width  = head.pulse_width;
        heat_request = head.heat_request;
    end

endmodule

// File: bench/adaptive_valve_duty_controller_unit_tb.sv
// ----------------------------------------------------------------------------
// adaptive_valve_duty_controller_unit_tb
// Sends zone readings tick by tick, with random bursts on the input side and
// random stalls on the result side. Each accepted reading goes through a
// local model of the zone width rules, and every valve drive result is
// checked field by field against the oldest expected result. The run steps
// through several register settings, including extreme settings.
// ----------------------------------------------------------------------------
module adaptive_valve_duty_controller_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_COUNT   = 12;
    localparam int DIR_ROWS      = 14;
    localparam int TEMP_MIN      = -500;
    localparam int TEMP_MAX      = 1500;

    typedef struct packed {
        logic [2:0]         zone;
        logic signed [11:0] measured;
        logic signed [11:0] target;
        logic               last;
    } reading_t;

    typedef struct packed {
        reading_t          rd;
        logic              typed;
        avdc_pkg::result_t drive;
    } dir_row_t;

    // block ports
    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               item_valid = 1'b0;
    logic               item_stall;
    logic [2:0]         zone = '0;
    logic signed [11:0] measured_temp = '0;
    logic signed [11:0] target_temp = '0;
    logic               last_zone = 1'b0;
    logic               result_valid;
    logic               result_stall = 1'b0;
    logic [2:0]         zone_out;
    logic               valve_open;
    logic               duty_active;
    logic [15:0]        pulse_width;
    logic               heat_request;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    // register and zone state as the block should hold it
    logic [15:0] cfg_reg [8];
    logic [15:0] next_cfg [8];
    int          hist [avdc_pkg::ZONES][3];
    int unsigned holdoff_ticks [avdc_pkg::ZONES];
    int unsigned below_ticks [avdc_pkg::ZONES];
    int unsigned rise_count [avdc_pkg::ZONES];
    int unsigned zone_width_q [avdc_pkg::ZONES];
    logic        hot_q [avdc_pkg::ZONES];
    logic        cold_q [avdc_pkg::ZONES];
    logic        heat_q [avdc_pkg::ZONES];
    int unsigned period_timer;
    int unsigned sample_timer;

    avdc_pkg::result_t pending_drives [$];
    int                mismatch_count = 0;

    // stimulus state
    int temp_now [avdc_pkg::ZONES];
    int temp_goal [avdc_pkg::ZONES];
    int temp_slope [avdc_pkg::ZONES];
    int next_zone_idx = 0;
    int zones_per_tick = avdc_pkg::ZONES;
    int burst_left = 0;
    bit drain_req = 1'b0;

    // receiver stall pattern and watchdog
    int stall_pct = 0;
    int stall_hold = 0;
    int cycle_count = 0;

    // directed rows, typed expectations only right after reset
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{'{3'd0, -12'sd500, 12'sd1500, 1'b0}, 1'b1, '{3'd0, 1'b0, 1'b0, 16'd120, 1'b1}},
        '{'{3'd1, 12'sd1500, -12'sd500, 1'b0}, 1'b1, '{3'd1, 1'b0, 1'b0, 16'd60, 1'b0}},
        '{'{3'd2, 12'sd0, 12'sd0, 1'b1}, 1'b1, '{3'd2, 1'b0, 1'b0, 16'd0, 1'b0}},
        '{'{3'd7, 12'sd1500, 12'sd1500, 1'b0}, 1'b0, '0},
        '{'{3'd3, -12'sd500, -12'sd500, 1'b0}, 1'b0, '0},
        '{'{3'd4, 12'sd901, 12'sd0, 1'b0}, 1'b0, '0},
        '{'{3'd5, 12'sd900, 12'sd1500, 1'b0}, 1'b0, '0},
        '{'{3'd6, -12'sd1, 12'sd0, 1'b1}, 1'b0, '0},
        '{'{3'd0, -12'sd500, -12'sd500, 1'b0}, 1'b0, '0},
        '{'{3'd1, 12'sd1500, 12'sd1500, 1'b1}, 1'b0, '0},
        '{'{3'd7, -12'sd500, 12'sd1500, 1'b1}, 1'b0, '0},
        '{'{3'd2, 12'sd1024, 12'sd1023, 1'b0}, 1'b0, '0},
        '{'{3'd3, 12'sd511, -12'sd256, 1'b0}, 1'b0, '0},
        '{'{3'd5, -12'sd256, 12'sd255, 1'b1}, 1'b0, '0}
    };

    adaptive_valve_duty_controller_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_stall    (item_stall),
        .zone          (zone),
        .measured_temp (measured_temp),
        .target_temp   (target_temp),
        .last_zone     (last_zone),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .zone_out      (zone_out),
        .valve_open    (valve_open),
        .duty_active   (duty_active),
        .pulse_width   (pulse_width),
        .heat_request  (heat_request),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [15:0] reg_mask(input logic [2:0] idx);
        case (idx)
            avdc_pkg::REG_HYSTERESIS:     return 16'h01FF;
            avdc_pkg::REG_OVERHEAT_LIMIT: return 16'h0FFF;
            avdc_pkg::REG_ZONE_ENABLE:    return 16'h00FF;
            default:                      return 16'hFFFF;
        endcase
    endfunction

    function automatic int unsigned sat_grow(input int unsigned w, input int unsigned d);
        return (w + d > 32'hFFFF) ? 32'hFFFF : w + d;
    endfunction

    function automatic int rand_temp();
        return int'($urandom_range(0, TEMP_MAX - TEMP_MIN)) + TEMP_MIN;
    endfunction

    function automatic int clamp_temp(input int v);
        if (v > TEMP_MAX)
            return TEMP_MAX;
        if (v < TEMP_MIN)
            return TEMP_MIN;
        return v;
    endfunction

    // zone width update and valve drive for one accepted reading
    function automatic avdc_pkg::result_t predict_valve_drive(input reading_t rd);
        avdc_pkg::result_t drive;
        int          z;
        int          m;
        int          hi;
        int          lo;
        int          top;
        int unsigned w;
        int unsigned step_sz;
        int unsigned period;
        int unsigned dflt;
        int unsigned wmax;
        logic        active;
        z       = int'(rd.zone);
        m       = int'($signed(rd.measured));
        hi      = int'($signed(rd.target)) + int'(cfg_reg[avdc_pkg::REG_HYSTERESIS]);
        lo      = int'($signed(rd.target)) - int'(cfg_reg[avdc_pkg::REG_HYSTERESIS]);
        top     = int'($signed(cfg_reg[avdc_pkg::REG_OVERHEAT_LIMIT][11:0]));
        step_sz = cfg_reg[avdc_pkg::REG_DUTY_STEP];
        period  = cfg_reg[avdc_pkg::REG_PWM_PERIOD];
        dflt    = cfg_reg[avdc_pkg::REG_DEFAULT_DUTY];
        wmax    = cfg_reg[avdc_pkg::REG_MAX_DUTY];
        w       = zone_width_q[z];

        // history shift on sample ticks
        if (sample_timer == 0)
        begin
            hist[z][2] = hist[z][1];
            hist[z][1] = hist[z][0];
            hist[z][0] = m;
        end

        if (holdoff_ticks[z] > 0)
        begin
            holdoff_ticks[z]--;
            // overshoot while heating: back off once
            if (m > hi && heat_q[z] && !hot_q[z])
            begin
                heat_q[z]     = 1'b0;
                rise_count[z] = 0;
                hot_q[z]      = 1'b1;
                w = (w > step_sz) ? w - step_sz : 0;
            end
            // falling fast: push once
            if (!cold_q[z] && hist[z][2] > hist[z][1] && hist[z][1] > m &&
                hist[z][2] - m > int'(avdc_pkg::TREND_DROP))
            begin
                w = sat_grow(w, step_sz);
                cold_q[z] = 1'b1;
            end
        end
        else
        begin
            // overheat falls back to the default width
            if (m > top && hist[z][1] > top && hist[z][2] > top)
                w = dflt;
            if (m > top && int'(w) >= int'(wmax) - int'(step_sz))
                w = dflt;
            if (m < lo)
            begin
                if (below_ticks[z] < 32'hFFFF)
                    below_ticks[z]++;
                if (below_ticks[z] > period / 100 && w < dflt)
                    w = dflt;
                cold_q[z] = 1'b0;
                heat_q[z] = 1'b1;
                if (hist[z][2] < hist[z][1] && hist[z][1] < m)
                begin
                    // already rising: wait a few chances, then nudge if slow
                    if (rise_count[z] < avdc_pkg::RISE_LIMIT)
                        rise_count[z]++;
                    else if (m - hist[z][2] < int'(avdc_pkg::SLOW_RISE))
                        w = sat_grow(w, step_sz);
                end
                else
                begin
                    w = sat_grow(w, step_sz);
                    if (lo - m > int'(avdc_pkg::FAR_BELOW))
                        w = sat_grow(w, step_sz);
                end
                if (w > wmax)
                    w = wmax;
                holdoff_ticks[z] = period * 2;
            end
            else
            begin
                heat_q[z]      = 1'b0;
                below_ticks[z] = 0;
                hot_q[z]       = 1'b0;
                rise_count[z]  = 0;
                if (m > hi)
                begin
                    if (hist[z][2] > hist[z][1] && hist[z][1] > m)
                    begin
                        // cooling but still far above: cut harder
                        if (hist[z][2] - hi > int'(avdc_pkg::FAR_ABOVE) &&
                            hist[z][1] - hi > int'(avdc_pkg::FAR_ABOVE) &&
                            m - hi > int'(avdc_pkg::FAR_ABOVE))
                        begin
                            if (w < step_sz * 3)
                                w = step_sz;
                            else
                                w = w - 2 * step_sz;
                        end
                    end
                    else
                    begin
                        if (w < step_sz * 2)
                            w = step_sz;
                        else
                            w = w - step_sz;
                        holdoff_ticks[z] = period;
                    end
                end
                else
                begin
                    cold_q[z] = 1'b0;
                end
            end
        end
        zone_width_q[z] = w & 32'hFFFF;

        // valve drive from the shared period timer
        active = int'(period_timer) > int'(period) - int'(zone_width_q[z]);
        drive.zone         = rd.zone;
        drive.duty_active  = active;
        drive.valve_open   = active && cfg_reg[avdc_pkg::REG_ZONE_ENABLE][z];
        drive.pulse_width  = zone_width_q[z][15:0];
        drive.heat_request = heat_q[z];

        // timers advance after the last zone of a tick
        if (rd.last)
        begin
            if (period_timer == 0)
                period_timer = period;
            if (sample_timer == 0)
                sample_timer = cfg_reg[avdc_pkg::REG_SAMPLE_INTERVAL];
            period_timer = (period_timer - 1) & 32'hFFFF;
            sample_timer = (sample_timer - 1) & 32'hFFFF;
        end
        return drive;
    endfunction

    // next reading: mostly ordered ticks with drifting temperatures, some noise
    function automatic reading_t next_zone_reading();
        reading_t rd;
        int       z;
        if ($urandom_range(0, 99) < 8)
        begin
            rd.zone     = 3'($urandom_range(0, avdc_pkg::ZONES - 1));
            rd.last     = 1'($urandom_range(0, 1));
            rd.measured = 12'(rand_temp());
            rd.target   = 12'(rand_temp());
        end
        else
        begin
            z = next_zone_idx;
            rd.zone = 3'(z);
            rd.last = (z >= zones_per_tick - 1);
            next_zone_idx = rd.last ? 0 : z + 1;
            if (rd.last && $urandom_range(0, 3) == 0)
                zones_per_tick = $urandom_range(1, avdc_pkg::ZONES);
            if ($urandom_range(0, 11) == 0)
                temp_slope[z] = int'($urandom_range(0, 50)) - 25;
            if ($urandom_range(0, 63) == 0)
                temp_goal[z] = rand_temp();
            temp_now[z] = temp_now[z] + temp_slope[z] + int'($urandom_range(0, 8)) - 4;
            if (temp_now[z] > TEMP_MAX || temp_now[z] < TEMP_MIN)
            begin
                temp_slope[z] = -temp_slope[z];
                temp_now[z]   = clamp_temp(temp_now[z]);
            end
            if ($urandom_range(0, 39) == 0)
                rd.measured = $urandom_range(0, 1) ? 12'(TEMP_MAX) : 12'(TEMP_MIN);
            else
                rd.measured = 12'(temp_now[z]);
            rd.target = 12'(temp_goal[z]);
        end
        return rd;
    endfunction

    // one zone transaction, then burst bookkeeping on the input side
    task automatic send_item(input reading_t rd, input logic typed,
                             input avdc_pkg::result_t typed_drive);
        avdc_pkg::result_t drive;
        item_valid    <= 1'b1;
        zone          <= rd.zone;
        measured_temp <= rd.measured;
        target_temp   <= rd.target;
        last_zone     <= rd.last;
        do
            @(posedge clk);
        while (item_stall);
        drive = predict_valve_drive(rd);
        pending_drives.push_back(typed ? typed_drive : drive);
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            if (drain_req || $urandom_range(0, 24) == 0)
            begin
                while (pending_drives.size() != 0)
                    @(posedge clk);
                drain_req = 1'b0;
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // write all registers back to back from next_cfg
    task automatic write_settings();
        for (int i = 0; i < 8; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= next_cfg[i];
            do
                @(posedge clk);
            while (!cfg_ready);
            cfg_reg[i] = next_cfg[i] & reg_mask(3'(i));
        end
        cfg_valid <= 1'b0;
    endtask

    // stop sending and let every result come back
    task automatic wait_idle();
        if (item_valid)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        burst_left = 0;
        while (pending_drives.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic report_field(input string name, input int unsigned want,
                                input int unsigned got);
        if (want != got)
        begin
            mismatch_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    // result side: stall pattern and checking
    always @(posedge clk)
    begin
        avdc_pkg::result_t want;
        if (stall_hold == 0)
        begin
            case ($urandom_range(0, 4))
                0, 1:    stall_pct = 0;
                2:       stall_pct = 25;
                3:       stall_pct = 60;
                default: stall_pct = 90;
            endcase
            stall_hold = $urandom_range(8, 150);
        end
        else
        begin
            stall_hold--;
        end
        result_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);

        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_drives.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: result for zone %0d with no transaction pending",
                         $time, zone_out);
            end
            else
            begin
                want = pending_drives.pop_front();
                report_field("zone_out", want.zone, zone_out);
                report_field("valve_open", want.valve_open, valve_open);
                report_field("duty_active", want.duty_active, duty_active);
                report_field("pulse_width", want.pulse_width, pulse_width);
                report_field("heat_request", want.heat_request, heat_request);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("adaptive_valve_duty_controller_unit_tb: FAIL");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        int n_items;

        // model state after reset
        cfg_reg[avdc_pkg::REG_SAMPLE_INTERVAL] = avdc_pkg::RST_SAMPLE_INTERVAL;
        cfg_reg[avdc_pkg::REG_HYSTERESIS]      = 16'(avdc_pkg::RST_HYSTERESIS);
        cfg_reg[avdc_pkg::REG_DUTY_STEP]       = avdc_pkg::RST_DUTY_STEP;
        cfg_reg[avdc_pkg::REG_OVERHEAT_LIMIT]  = 16'(avdc_pkg::RST_OVERHEAT_LIMIT);
        cfg_reg[avdc_pkg::REG_DEFAULT_DUTY]    = avdc_pkg::RST_DEFAULT_DUTY;
        cfg_reg[avdc_pkg::REG_MAX_DUTY]        = avdc_pkg::RST_MAX_DUTY;
        cfg_reg[avdc_pkg::REG_PWM_PERIOD]      = avdc_pkg::RST_PWM_PERIOD;
        cfg_reg[avdc_pkg::REG_ZONE_ENABLE]     = 16'(avdc_pkg::RST_ZONE_ENABLE);
        for (int z = 0; z < avdc_pkg::ZONES; z++)
        begin
            hist[z][0]       = 0;
            hist[z][1]       = 0;
            hist[z][2]       = 0;
            holdoff_ticks[z] = 0;
            below_ticks[z]   = 0;
            rise_count[z]    = 0;
            zone_width_q[z]  = 0;
            hot_q[z]         = 1'b0;
            cold_q[z]        = 1'b0;
            heat_q[z]        = 1'b0;
        end
        period_timer = 0;
        sample_timer = 0;

        // reset
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed rows at reset settings
        for (int r = 0; r < DIR_ROWS; r++)
            send_item(dir_rows[r].rd, dir_rows[r].typed, dir_rows[r].drive);
        wait_idle();

        // random phases, the first three at extreme settings
        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            case (p)
                0:
                begin
                    next_cfg[avdc_pkg::REG_SAMPLE_INTERVAL] = 16'd1;
                    next_cfg[avdc_pkg::REG_HYSTERESIS]      = 16'd0;
                    next_cfg[avdc_pkg::REG_DUTY_STEP]       = 16'd0;
                    next_cfg[avdc_pkg::REG_OVERHEAT_LIMIT]  = 16'(TEMP_MIN);
                    next_cfg[avdc_pkg::REG_DEFAULT_DUTY]    = 16'd0;
                    next_cfg[avdc_pkg::REG_MAX_DUTY]        = 16'd0;
                    next_cfg[avdc_pkg::REG_PWM_PERIOD]      = 16'd1;
                    next_cfg[avdc_pkg::REG_ZONE_ENABLE]     = 16'h00FF;
                end
                1:
                begin
                    next_cfg[avdc_pkg::REG_SAMPLE_INTERVAL] = 16'hFFFF;
                    next_cfg[avdc_pkg::REG_HYSTERESIS]      = 16'd500;
                    next_cfg[avdc_pkg::REG_DUTY_STEP]       = 16'hFFFF;
                    next_cfg[avdc_pkg::REG_OVERHEAT_LIMIT]  = 16'(TEMP_MAX);
                    next_cfg[avdc_pkg::REG_DEFAULT_DUTY]    = 16'hFFFF;
                    next_cfg[avdc_pkg::REG_MAX_DUTY]        = 16'hFFFF;
                    next_cfg[avdc_pkg::REG_PWM_PERIOD]      = 16'hFFFF;
                    next_cfg[avdc_pkg::REG_ZONE_ENABLE]     = 16'h0000;
                end
                2:
                begin
                    // large steps against a wide ceiling reach width saturation
                    next_cfg[avdc_pkg::REG_SAMPLE_INTERVAL] = 16'd1;
                    next_cfg[avdc_pkg::REG_HYSTERESIS]      = 16'd500;
                    next_cfg[avdc_pkg::REG_DUTY_STEP]       = 16'hFFFF;
                    next_cfg[avdc_pkg::REG_OVERHEAT_LIMIT]  = 16'(TEMP_MAX);
                    next_cfg[avdc_pkg::REG_DEFAULT_DUTY]    = 16'd0;
                    next_cfg[avdc_pkg::REG_MAX_DUTY]        = 16'hFFFF;
                    next_cfg[avdc_pkg::REG_PWM_PERIOD]      = 16'd2;
                    next_cfg[avdc_pkg::REG_ZONE_ENABLE]     = 16'h00A5;
                end
                default:
                begin
                    next_cfg[avdc_pkg::REG_SAMPLE_INTERVAL] = ($urandom_range(0, 3) == 0)
                        ? 16'($urandom_range(5, 40)) : 16'($urandom_range(1, 3));
                    next_cfg[avdc_pkg::REG_HYSTERESIS] = ($urandom_range(0, 5) == 0)
                        ? 16'($urandom_range(0, 500)) : 16'($urandom_range(0, 40));
                    next_cfg[avdc_pkg::REG_DUTY_STEP] = ($urandom_range(0, 7) == 0)
                        ? 16'($urandom_range(1000, 65535)) : 16'($urandom_range(0, 200));
                    next_cfg[avdc_pkg::REG_OVERHEAT_LIMIT] = ($urandom_range(0, 3) == 0)
                        ? 16'(rand_temp()) : 16'($urandom_range(300, 1300));
                    next_cfg[avdc_pkg::REG_DEFAULT_DUTY] = 16'($urandom_range(0, 1500));
                    next_cfg[avdc_pkg::REG_MAX_DUTY] = ($urandom_range(0, 5) == 0)
                        ? 16'($urandom_range(0, 65535)) : 16'($urandom_range(0, 2000));
                    next_cfg[avdc_pkg::REG_PWM_PERIOD] = ($urandom_range(0, 5) == 0)
                        ? 16'($urandom_range(100, 2000)) : 16'($urandom_range(1, 60));
                    next_cfg[avdc_pkg::REG_ZONE_ENABLE] = 16'($urandom_range(0, 255));
                end
            endcase
            write_settings();

            // fresh temperature profile per phase
            for (int z = 0; z < avdc_pkg::ZONES; z++)
            begin
                temp_goal[z]  = rand_temp();
                temp_now[z]   = clamp_temp(temp_goal[z] + int'($urandom_range(0, 200)) - 100);
                temp_slope[z] = int'($urandom_range(0, 50)) - 25;
            end
            next_zone_idx  = 0;
            zones_per_tick = avdc_pkg::ZONES;

            n_items = (p == 1) ? 100 : 165 + $urandom_range(0, 30);
            for (int k = 0; k < n_items; k++)
            begin
                if (k == n_items / 2)
                    drain_req = 1'b1;
                send_item(next_zone_reading(), 1'b0, '0);
            end
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("adaptive_valve_duty_controller_unit_tb: PASS");
        else
            $display("adaptive_valve_duty_controller_unit_tb: FAIL");
        $finish;
    end

endmodule
